// ===== src/pps_pkg.sv =====
package pps_pkg;

    localparam int MAX_PROCS  = 16;
    localparam int BURST_BITS = 8;
    localparam int PRIO_BITS  = 8;
    localparam int IDX_W      = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W      = $clog2(MAX_PROCS + 1);
    localparam int NUM_W      = 4;
    localparam int TIME_W     = 12;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

    typedef struct packed {
        logic [BURST_BITS-1:0] burst;
        logic [PRIO_BITS-1:0]  prio;
        logic [IDX_W-1:0]      idx;
    } t_proc;

    typedef struct packed {
        logic  valid;
        t_proc proc;
    } t_slot;

    typedef struct packed {
        logic load;
        logic shift;
    } t_chain_ctl;

    typedef struct packed {
        logic [TIME_W-1:0] wait_t;
        logic [TIME_W-1:0] tat;
    } t_result;

    localparam int RES_W = $bits(t_result);

endpackage

// ===== src/pps_ram.sv =====
module pps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/pps_cell.sv =====
module pps_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_chain_ctl i_ctl,
    input  pps_pkg::t_proc     i_new,
    input  pps_pkg::t_slot     i_prev,
    input  logic               i_prev_ahead,
    input  pps_pkg::t_slot     i_next,
    output pps_pkg::t_slot     o_slot,
    output logic               o_ahead
);
    import pps_pkg::*;

    t_slot r_slot;
    t_slot n_slot;
    logic  ahead;

    // New item sorts at or before this cell; equal priority goes behind (later index).
    assign ahead = !r_slot.valid || (i_new.prio < r_slot.proc.prio);

    always_comb begin
        n_slot = r_slot;
        if (i_ctl.shift) begin
            n_slot = i_next;
        end else if (i_ctl.load && ahead) begin
            if (i_prev_ahead) begin
                n_slot = i_prev;
            end else begin
                n_slot.valid = 1'b1;
                n_slot.proc  = i_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.valid <= 1'b0;
        end else begin
            r_slot <= n_slot;
        end
    end

    assign o_slot  = r_slot;
    assign o_ahead = ahead;

endmodule

// ===== src/pps_chain.sv =====
module pps_chain (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pps_pkg::t_chain_ctl i_ctl,
    input  pps_pkg::t_proc     i_new,
    output pps_pkg::t_slot     o_head
);
    import pps_pkg::*;

    t_slot w_slot  [MAX_PROCS];
    logic  w_ahead [MAX_PROCS];

    for (genvar g = 0; g < MAX_PROCS; g++) begin : g_cell
        t_slot w_prev;
        t_slot w_next;
        logic  w_prev_ahead;

        if (g == 0) begin : g_first
            assign w_prev       = '0;
            assign w_prev_ahead = 1'b0;
        end else begin : g_mid
            assign w_prev       = w_slot[g-1];
            assign w_prev_ahead = w_ahead[g-1];
        end

        if (g == MAX_PROCS - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_inner
            assign w_next = w_slot[g+1];
        end

        pps_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (i_ctl),
            .i_new        (i_new),
            .i_prev       (w_prev),
            .i_prev_ahead (w_prev_ahead),
            .i_next       (w_next),
            .o_slot       (w_slot[g]),
            .o_ahead      (w_ahead[g])
        );
    end

    assign o_head = w_slot[0];

endmodule

// ===== src/preemptive_priority_scheduler.sv =====
// Preemptive priority scheduler, all processes arriving at tick 0.
// Input channel (i_in_valid / o_in_ready): one process per transfer with its
// burst time and priority; i_last_process closes the set and starts the run.
// Up to 16 processes are kept; further ones are dropped, but a dropped item
// marked last still starts the run. Loading takes one item per cycle.
// Each transfer is inserted into a sorted row of cells (priority, then load
// order), so the row holds the execution order once the set is loaded.
// Run: the row shifts its head out once a cycle, adding the burst to the
// tick clock and writing finish and waiting time into a result RAM by load
// index; the run ends when the head is seen empty.
// Output channel (o_out_valid / i_out_ready): one result per process in load
// order, each read from the RAM and then shown; o_last_result marks the
// final one. A stalled receiver holds the current result; nothing is lost.
// Input is not taken from the last-item transfer until the final result is
// taken. Reset empties the row and returns the block to loading.
module preemptive_priority_scheduler (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [pps_pkg::BURST_BITS-1:0] i_burst_time,
    input  logic [pps_pkg::PRIO_BITS-1:0]  i_priority_level,
    input  logic                           i_last_process,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [pps_pkg::NUM_W-1:0]      o_process_number,
    output logic [pps_pkg::TIME_W-1:0]     o_waiting_time,
    output logic [pps_pkg::TIME_W-1:0]     o_turnaround_time,
    output logic                           o_last_result
);
    import pps_pkg::*;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_DRAIN = 4'b0010,
        S_FETCH = 4'b0100,
        S_SHOW  = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_ptr, n_ptr;
    logic [TIME_W-1:0] r_tick, n_tick;

    t_chain_ctl        chain_ctl;
    t_proc             new_proc;
    t_slot             head;
    logic              in_xfer;
    logic              has_room;
    logic              ptr_last;
    logic [TIME_W:0]   tick_sum;
    logic [TIME_W-1:0] tick_sat;
    t_result           wr_res;
    logic              wr_en;
    logic [RES_W-1:0]  rd_data;
    t_result           rd_res;

    assign o_in_ready = (r_state == S_LOAD);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign has_room   = (r_cnt < CNT_W'(MAX_PROCS));

    assign new_proc.burst = i_burst_time;
    assign new_proc.prio  = i_priority_level;
    assign new_proc.idx   = r_cnt[IDX_W-1:0];

    assign chain_ctl.load  = in_xfer && has_room;
    assign chain_ctl.shift = (r_state == S_DRAIN) && head.valid;

    pps_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (chain_ctl),
        .i_new   (new_proc),
        .o_head  (head)
    );

    // Head runs to completion: advance the clock by its whole burst.
    assign tick_sum = {1'b0, r_tick} + (TIME_W+1)'(head.proc.burst);
    assign tick_sat = tick_sum[TIME_W] ? TIME_MAX : tick_sum[TIME_W-1:0];

    always_comb begin
        // Zero burst never runs and finishes at tick 0.
        if (head.proc.burst == '0) begin
            wr_res.tat = '0;
        end else begin
            wr_res.tat = tick_sat;
        end
        wr_res.wait_t = wr_res.tat - TIME_W'(head.proc.burst);
    end

    assign wr_en = chain_ctl.shift;

    pps_ram #(
        .WIDTH (RES_W),
        .DEPTH (MAX_PROCS)
    ) u_res_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (head.proc.idx),
        .i_wr_data (wr_res),
        .i_rd_addr (r_ptr),
        .o_rd_data (rd_data)
    );

    assign rd_res   = t_result'(rd_data);
    assign ptr_last = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_cnt);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ptr   = r_ptr;
        n_tick  = r_tick;
        case (r_state)
            S_LOAD: begin
                if (in_xfer) begin
                    if (has_room) begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                    if (i_last_process) begin
                        n_state = S_DRAIN;
                        n_tick  = '0;
                    end
                end
            end
            S_DRAIN: begin
                if (head.valid) begin
                    n_tick = tick_sat;
                end else begin
                    n_state = S_FETCH;
                    n_ptr   = '0;
                end
            end
            S_FETCH: begin
                n_state = S_SHOW;
            end
            S_SHOW: begin
                if (i_out_ready) begin
                    if (ptr_last) begin
                        n_state = S_LOAD;
                        n_cnt   = '0;
                    end else begin
                        n_state = S_FETCH;
                        n_ptr   = r_ptr + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_ptr   <= '0;
            r_tick  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ptr   <= n_ptr;
            r_tick  <= n_tick;
        end
    end

    assign o_out_valid       = (r_state == S_SHOW);
    assign o_process_number  = NUM_W'(r_ptr);
    assign o_waiting_time    = rd_res.wait_t;
    assign o_turnaround_time = rd_res.tat;
    assign o_last_result     = ptr_last;

endmodule

// ===== bench/preemptive_priority_scheduler_test.sv =====
module preemptive_priority_scheduler_test;
    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    typedef struct {
        logic [BURST_BITS-1:0] burst;
        logic [PRIO_BITS-1:0]  prio;
    } t_job;

    typedef struct {
        logic [NUM_W-1:0]  number;
        logic [TIME_W-1:0] waiting;
        logic [TIME_W-1:0] turnaround;
        logic              closing;
    } t_outcome;

    logic                  i_clk            = 1'b0;
    logic                  i_rst_n          = 1'b0;
    logic                  i_in_valid       = 1'b0;
    logic [BURST_BITS-1:0] i_burst_time     = '0;
    logic [PRIO_BITS-1:0]  i_priority_level = '0;
    logic                  i_last_process   = 1'b0;
    logic                  i_out_ready      = 1'b0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic [NUM_W-1:0]      o_process_number;
    logic [TIME_W-1:0]     o_waiting_time;
    logic [TIME_W-1:0]     o_turnaround_time;
    logic                  o_last_result;

    t_job     loaded_jobs[$];
    t_job     job_batch[$];
    t_outcome pending_outcomes[$];
    t_outcome head_outcome;
    int       mismatches = 0;
    bit       calm       = 1'b0;

    preemptive_priority_scheduler dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_burst_time      (i_burst_time),
        .i_priority_level  (i_priority_level),
        .i_last_process    (i_last_process),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_process_number  (o_process_number),
        .o_waiting_time    (o_waiting_time),
        .o_turnaround_time (o_turnaround_time),
        .o_last_result     (o_last_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_out_ready <= calm || ($urandom_range(99) >= 19);
    end

    // Run the loaded set to completion and queue one outcome per process.
    // With every process present at tick zero, the chosen one runs to the end.
    function automatic void schedule_set();
        int finish_tick[MAX_PROCS];
        bit served[MAX_PROCS];
        int clock_ticks;
        int pick;
        int waited;
        t_outcome res;
        clock_ticks = 0;
        for (int n = 0; n < loaded_jobs.size(); n++) begin
            served[n]      = (loaded_jobs[n].burst == 0);
            finish_tick[n] = 0;
        end
        for (int round = 0; round < loaded_jobs.size(); round++) begin
            pick = -1;
            for (int n = 0; n < loaded_jobs.size(); n++) begin
                if (!served[n] && (pick < 0 || loaded_jobs[n].prio < loaded_jobs[pick].prio))
                    pick = n;
            end
            if (pick >= 0) begin
                clock_ticks += loaded_jobs[pick].burst;
                finish_tick[pick] = clock_ticks;
                served[pick] = 1'b1;
            end
        end
        for (int n = 0; n < loaded_jobs.size(); n++) begin
            waited = finish_tick[n] - int'(loaded_jobs[n].burst);
            if (waited < 0)
                waited = 0;
            res.number     = n[NUM_W-1:0];
            res.turnaround = (finish_tick[n] > int'(TIME_MAX)) ? TIME_MAX
                                                                : TIME_W'(finish_tick[n]);
            res.waiting    = (waited > int'(TIME_MAX)) ? TIME_MAX : TIME_W'(waited);
            res.closing    = (n == loaded_jobs.size() - 1);
            pending_outcomes.push_back(res);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_outcomes.size() == 0) begin
                $error("unexpected result for process_number %0d", o_process_number);
                mismatches++;
            end else begin
                head_outcome = pending_outcomes.pop_front();
                if (o_process_number !== head_outcome.number) begin
                    $error("process_number: expected %0d, got %0d",
                           head_outcome.number, o_process_number);
                    mismatches++;
                end
                if (o_waiting_time !== head_outcome.waiting) begin
                    $error("waiting_time: expected %0d, got %0d",
                           head_outcome.waiting, o_waiting_time);
                    mismatches++;
                end
                if (o_turnaround_time !== head_outcome.turnaround) begin
                    $error("turnaround_time: expected %0d, got %0d",
                           head_outcome.turnaround, o_turnaround_time);
                    mismatches++;
                end
                if (o_last_result !== head_outcome.closing) begin
                    $error("last_result: expected %0b, got %0b",
                           head_outcome.closing, o_last_result);
                    mismatches++;
                end
            end
        end
    end

    // Entered at a clock edge where valid has not been written yet.
    task automatic send_process(input logic [BURST_BITS-1:0] burst,
                                input logic [PRIO_BITS-1:0] prio, input logic last);
        t_job job;
        while (!calm && $urandom_range(99) < 19) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_burst_time     <= burst;
        i_priority_level <= prio;
        i_last_process   <= last;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        job.burst = burst;
        job.prio  = prio;
        // drop anything past capacity, but a dropped last item still starts the run
        if (loaded_jobs.size() < MAX_PROCS)
            loaded_jobs.push_back(job);
        if (last) begin
            schedule_set();
            loaded_jobs.delete();
        end
    endtask

    task automatic send_batch();
        for (int n = 0; n < job_batch.size(); n++)
            send_process(job_batch[n].burst, job_batch[n].prio, n == job_batch.size() - 1);
    endtask

    task automatic add_job(input int burst, input int prio);
        t_job job;
        job.burst = BURST_BITS'(burst);
        job.prio  = PRIO_BITS'(prio);
        job_batch.push_back(job);
    endtask

    function automatic int pick_value(input int mode, input int bits);
        int top;
        top = (1 << bits) - 1;
        case (mode)
            0: return $urandom_range(top);
            1: return $urandom_range(3);
            default: return $urandom_range(1) ? top : 0;
        endcase
    endfunction

    // Mostly in-range sets; about one in ten overruns the capacity.
    task automatic build_random_batch(output int kept);
        int count;
        int burst_mode;
        int prio_mode;
        count = ($urandom_range(9) == 0) ? $urandom_range(MAX_PROCS + 1, MAX_PROCS + 4)
                                         : $urandom_range(1, MAX_PROCS);
        burst_mode = $urandom_range(2);
        prio_mode  = $urandom_range(2);
        job_batch.delete();
        for (int n = 0; n < count; n++)
            add_job(pick_value(burst_mode, BURST_BITS), pick_value(prio_mode, PRIO_BITS));
        kept = (count > MAX_PROCS) ? MAX_PROCS : count;
    endtask

    task automatic test_lone_process();
        job_batch.delete();
        add_job(255, 255);
        send_batch();
        job_batch.delete();
        add_job(0, 0);
        send_batch();
    endtask

    task automatic test_zero_bursts();
        job_batch.delete();
        add_job(0, 5);
        add_job(3, 5);
        add_job(0, 0);
        add_job(2, 0);
        send_batch();
    endtask

    task automatic test_equal_priorities();
        job_batch.delete();
        add_job(4, 7);
        add_job(1, 7);
        add_job(9, 7);
        send_batch();
    endtask

    task automatic test_full_capacity();
        job_batch.delete();
        for (int n = 0; n < MAX_PROCS; n++)
            add_job(255, (n * 37 + 255) % 256);
        add_job(17, 1);
        send_batch();
    endtask

    task automatic test_paused_sets();
        int kept;
        repeat (3) begin
            build_random_batch(kept);
            send_batch();
            i_in_valid <= 1'b0;
            wait (pending_outcomes.size() == 0);
            @(posedge i_clk);
        end
    endtask

    task automatic test_back_to_back();
        int kept;
        calm = 1'b1;
        repeat (4) begin
            build_random_batch(kept);
            send_batch();
        end
        calm = 1'b0;
    endtask

    task automatic test_random_sets();
        int loaded;
        int kept;
        loaded = 0;
        while (loaded < 230) begin
            build_random_batch(kept);
            send_batch();
            loaded += kept;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_lone_process();
        test_zero_bursts();
        test_equal_priorities();
        test_full_capacity();
        test_paused_sets();
        test_back_to_back();
        test_random_sets();
        i_in_valid <= 1'b0;
        wait (pending_outcomes.size() == 0);
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_outcomes.size() == 0)
            $display("PASS preemptive_priority_scheduler");
        else
            $display("FAIL preemptive_priority_scheduler");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAIL preemptive_priority_scheduler");
        $finish;
    end

endmodule
